// ===== rtl/core/bpid_pkg.sv =====
package bpid_pkg;

    // Default limits on the image header fields
    localparam int MAX_DIM_DEF       = 4096;
    localparam int MAX_INFO_SIZE_DEF = 1024;

    // Fixed file format constants
    localparam logic [15:0] BMP_SIG       = 16'h424D;
    localparam int          MIN_INFO_SIZE = 40;

    // Result field widths
    localparam int POS_W   = 12;
    localparam int TDATA_W = 64;

    // Result kinds
    localparam logic [1:0] KIND_PALETTE  = 2'd0;
    localparam logic [1:0] KIND_PIXEL    = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;
    localparam logic [1:0] KIND_COMPLETE = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_SIGNATURE  = 2'd0;
    localparam logic [1:0] ERR_COMPRESSED = 2'd1;
    localparam logic [1:0] ERR_DEPTH      = 2'd2;
    localparam logic [1:0] ERR_SIZE       = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [7:0]       color_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [1:0]       error_code;
    } t_result;

endpackage

// ===== rtl/core/bmp_palette_image_decoder.sv =====
// Streaming decoder for uncompressed 4 bpp and 8 bpp palette BMP files. Feed the file
// one byte per request on the slave side, with tuser high on the first byte of each
// file; the parse restarts there. The block checks the "BM" signature, reads the
// info header (size, width, height, bit count, compression) and rejects compressed
// files, depths other than 4 and 8, and sizes out of range with one error result.
// It then emits every palette entry (tuser = 0), every pixel of the image rows with
// row 0 at the top (tuser = 1), padding pixels dropped, and an image-complete result
// (tuser = 3) on the last byte. After an error or completion all bytes are dropped
// until the next start byte. Each byte is decoded in the cycle it is accepted and its
// results go to a three-entry result buffer that drains one result per cycle while
// the receiver is ready; tlast marks the final result of a byte. Bytes with zero or
// one result (header, palette and 8 bpp pixel bytes) thus stream at one byte per
// clock; a 4 bpp byte with two pixels or the last byte of an image (up to three
// results) holds the single output port until its results leave. The next byte is
// taken in the same cycle the final result of the previous byte leaves.
module bmp_palette_image_decoder #(
    parameter int MAX_DIM       = bpid_pkg::MAX_DIM_DEF,
    parameter int MAX_INFO_SIZE = bpid_pkg::MAX_INFO_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave side: file bytes
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,   // [7:0] file_byte
    input  logic                         i_s_axis_tuser,   // [0] start_file
    // master side: decoded results
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [11:0] pos_x, [23:12] pos_y, [31:24] color_index, [39:32] red,
    // [47:40] green, [55:48] blue, [57:56] error_code, [63:58] zero
    output logic [bpid_pkg::TDATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]                   o_m_axis_tuser,   // [1:0] kind
    output logic                         o_m_axis_tlast    // last_of_run
);

    import bpid_pkg::*;

    // Width of a stored dimension, of the column and row byte counters (which may run
    // up to seven past the width inside the row padding), and of the header counter.
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int COL_W  = DIM_W + 1;
    localparam int INFO_W = $clog2(MAX_INFO_SIZE + 1);
    localparam int HC_W   = $clog2(MAX_INFO_SIZE + 15);

    typedef enum logic [3:0] {
        PH_HDR  = 4'b0001,
        PH_PAL  = 4'b0010,
        PH_PIX  = 4'b0100,
        PH_IDLE = 4'b1000
    } t_phase;

    // Parser state
    t_phase             r_phase, n_phase;
    logic [HC_W-1:0]    r_hc, n_hc;
    logic [31:0]        r_fs, n_fs;
    logic [INFO_W-1:0]  r_info, n_info;
    logic [DIM_W-1:0]   r_width, n_width;
    logic [DIM_W-1:0]   r_height, n_height;
    logic               r_size_bad, n_size_bad;
    logic               r_bpp_ok, n_bpp_ok;
    logic               r_bpp4, n_bpp4;
    logic [7:0]         r_pal_cnt, n_pal_cnt;
    logic [23:0]        r_quad, n_quad;
    logic [COL_W-1:0]   r_rbc, n_rbc;
    logic [COL_W-1:0]   r_col, n_col;
    logic [DIM_W-1:0]   r_row, n_row;

    // Result buffer: entry 0 is the one on the output
    t_result            r_res [3];
    t_result            n_res [3];
    logic [1:0]         r_cnt, n_cnt;

    // Working values
    t_phase             cur_phase;
    logic [HC_W-1:0]    cur_hc;
    logic [31:0]        cur_fs;
    logic               in_acc;
    logic               out_pop;
    logic [COL_W-1:0]   wz;
    logic [COL_W-1:0]   stride;
    logic [COL_W-1:0]   w_plus3;
    logic [COL_W-1:0]   w_plus7;
    logic [COL_W-1:0]   col2;
    logic [COL_W-1:0]   rbc_inc;
    logic [DIM_W-1:0]   pix_y;
    logic [DIM_W-1:0]   row_inc;
    logic               dim_bad;
    logic [7:0]         pal_last;
    t_result            res_tmp;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_pop = o_m_axis_tvalid && i_m_axis_tready;

    // Take a byte when the buffer is empty or its final result leaves now
    assign o_s_axis_tready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_m_axis_tready);

    // Start byte restarts the parse from the reset state
    assign cur_phase = i_s_axis_tuser ? PH_HDR : r_phase;
    assign cur_hc    = i_s_axis_tuser ? '0 : r_hc;
    assign cur_fs    = i_s_axis_tuser ? '0 : r_fs;

    // Row stride in bytes, padded to 32 bits
    assign wz      = COL_W'(r_width);
    assign w_plus3 = wz + COL_W'(3);
    assign w_plus7 = wz + COL_W'(7);
    assign stride  = r_bpp4 ? {1'b0, w_plus7[COL_W-1:3], 2'b00}
                            : {w_plus3[COL_W-1:2], 2'b00};

    assign col2     = r_col + COL_W'(1);
    assign rbc_inc  = r_rbc + COL_W'(1);
    assign row_inc  = r_row + DIM_W'(1);
    assign pix_y    = r_height - DIM_W'(1) - r_row;
    assign pal_last = r_bpp4 ? 8'd15 : 8'd255;

    always_comb begin
        n_phase    = cur_phase;
        n_hc       = cur_hc;
        n_fs       = cur_fs;
        n_info     = r_info;
        n_width    = r_width;
        n_height   = r_height;
        n_size_bad = r_size_bad;
        n_bpp_ok   = r_bpp_ok;
        n_bpp4     = r_bpp4;
        n_pal_cnt  = r_pal_cnt;
        n_quad     = r_quad;
        n_rbc      = r_rbc;
        n_col      = r_col;
        n_row      = r_row;
        n_cnt      = 2'd0;
        dim_bad    = 1'b0;
        res_tmp    = '0;
        for (int k = 0; k < 3; k++) begin
            n_res[k] = '0;
        end

        case (cur_phase)
            PH_HDR: begin
                // Shift the byte in, little-endian
                n_fs = {i_s_axis_tdata, cur_fs[31:8]};
                n_hc = cur_hc + HC_W'(1);
                dim_bad = (n_fs == 32'd0) || (n_fs > 32'(MAX_DIM));
                if (cur_hc == HC_W'(1)) begin
                    if ({n_fs[23:16], n_fs[31:24]} != BMP_SIG) begin
                        res_tmp.kind       = KIND_ERROR;
                        res_tmp.error_code = ERR_SIGNATURE;
                        n_res[0]           = res_tmp;
                        n_cnt              = 2'd1;
                        n_phase            = PH_IDLE;
                    end
                end else if (cur_hc == HC_W'(17)) begin
                    n_info     = INFO_W'(n_fs);
                    n_size_bad = (n_fs < 32'(MIN_INFO_SIZE)) ||
                                 (n_fs > 32'(MAX_INFO_SIZE));
                end else if (cur_hc == HC_W'(21)) begin
                    n_width    = DIM_W'(n_fs);
                    n_size_bad = r_size_bad || dim_bad;
                end else if (cur_hc == HC_W'(25)) begin
                    n_height   = DIM_W'(n_fs);
                    n_size_bad = r_size_bad || dim_bad;
                end else if (cur_hc == HC_W'(29)) begin
                    n_bpp_ok = (n_fs[31:16] == 16'd4) || (n_fs[31:16] == 16'd8);
                    n_bpp4   = (n_fs[31:16] == 16'd4);
                end else if (cur_hc == HC_W'(33)) begin
                    // Validate in order: compression, depth, sizes
                    res_tmp.kind = KIND_ERROR;
                    if (n_fs != 32'd0) begin
                        res_tmp.error_code = ERR_COMPRESSED;
                    end else if (!r_bpp_ok) begin
                        res_tmp.error_code = ERR_DEPTH;
                    end else begin
                        res_tmp.error_code = ERR_SIZE;
                    end
                    if (n_fs != 32'd0 || !r_bpp_ok || r_size_bad) begin
                        n_res[0] = res_tmp;
                        n_cnt    = 2'd1;
                        n_phase  = PH_IDLE;
                    end
                end else if (cur_hc > HC_W'(33) &&
                             n_hc == HC_W'(r_info) + HC_W'(14)) begin
                    // Skip to the palette
                    n_phase   = PH_PAL;
                    n_hc      = '0;
                    n_pal_cnt = '0;
                end
            end
            PH_PAL: begin
                // Gather blue, green, red; emit on the reserved byte
                n_hc = {{(HC_W-2){1'b0}}, cur_hc[1:0] + 2'd1};
                if (cur_hc[1:0] != 2'd3) begin
                    n_quad = {r_quad[15:0], i_s_axis_tdata};
                end else begin
                    res_tmp.kind  = KIND_PALETTE;
                    res_tmp.pos_x = POS_W'(r_pal_cnt);
                    res_tmp.red   = r_quad[7:0];
                    res_tmp.green = r_quad[15:8];
                    res_tmp.blue  = r_quad[23:16];
                    n_res[0]      = res_tmp;
                    n_cnt         = 2'd1;
                    n_pal_cnt     = r_pal_cnt + 8'd1;
                    if (r_pal_cnt == pal_last) begin
                        n_phase = PH_PIX;
                        n_rbc   = '0;
                        n_col   = '0;
                        n_row   = '0;
                    end
                end
            end
            PH_PIX: begin
                res_tmp.kind  = KIND_PIXEL;
                res_tmp.pos_y = POS_W'(pix_y);
                if (r_bpp4) begin
                    // High nibble first, drop pixels in the row padding
                    if (r_col < wz) begin
                        res_tmp.pos_x       = POS_W'(r_col);
                        res_tmp.color_index = {4'd0, i_s_axis_tdata[7:4]};
                        n_res[n_cnt]        = res_tmp;
                        n_cnt               = n_cnt + 2'd1;
                    end
                    if (col2 < wz) begin
                        res_tmp.pos_x       = POS_W'(col2);
                        res_tmp.color_index = {4'd0, i_s_axis_tdata[3:0]};
                        n_res[n_cnt]        = res_tmp;
                        n_cnt               = n_cnt + 2'd1;
                    end
                    n_col = r_col + COL_W'(2);
                end else begin
                    if (r_col < wz) begin
                        res_tmp.pos_x       = POS_W'(r_col);
                        res_tmp.color_index = i_s_axis_tdata;
                        n_res[n_cnt]        = res_tmp;
                        n_cnt               = n_cnt + 2'd1;
                    end
                    n_col = col2;
                end
                n_rbc = rbc_inc;
                if (rbc_inc == stride) begin
                    // Advance to the next row
                    n_rbc = '0;
                    n_col = '0;
                    n_row = row_inc;
                    if (row_inc == r_height) begin
                        n_res[n_cnt]      = '0;
                        n_res[n_cnt].kind = KIND_COMPLETE;
                        n_cnt             = n_cnt + 2'd1;
                        n_phase           = PH_IDLE;
                    end
                end
            end
            PH_IDLE: begin
                // Drop bytes until the next start byte
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Parser state advances on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_hc    <= '0;
            r_fs    <= '0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_hc    <= n_hc;
            r_fs    <= n_fs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_info     <= n_info;
            r_width    <= n_width;
            r_height   <= n_height;
            r_size_bad <= n_size_bad;
            r_bpp_ok   <= n_bpp_ok;
            r_bpp4     <= n_bpp4;
            r_pal_cnt  <= n_pal_cnt;
            r_quad     <= n_quad;
            r_rbc      <= n_rbc;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

    // Result buffer: load on accept, shift down on each output request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (in_acc) begin
            r_cnt <= n_cnt;
        end else if (out_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < 3; k++) begin
                r_res[k] <= n_res[k];
            end
        end else if (out_pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tlast  = (r_cnt == 2'd1);
    assign o_m_axis_tuser  = r_res[0].kind;
    assign o_m_axis_tdata  = {6'd0, r_res[0].error_code, r_res[0].blue, r_res[0].green,
                              r_res[0].red, r_res[0].color_index, r_res[0].pos_y,
                              r_res[0].pos_x};

`ifndef ASSERT_OFF
    // Pixel rows stay inside the image height
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIX) |-> (r_row < r_height))
        else $error("row counter beyond image height");

    // Palette counter stays inside a 16-entry palette at 4 bpp
    a_pal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAL && r_bpp4) |-> (r_pal_cnt < 8'd16))
        else $error("palette counter beyond 4 bpp palette");

    // Buffer empties after the final result of a byte unless a byte is taken
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_pop && o_m_axis_tlast && !in_acc) |=> !o_m_axis_tvalid)
        else $error("result buffer not empty after final result");
`endif

endmodule

// ===== tb/sv/tb_bmp_palette_image_decoder.sv =====
module tb_bmp_palette_image_decoder;
    import bpid_pkg::*;

    localparam int HOLD_CYCLES   = 400;    // receiver hold-off used to back up the block
    localparam int SETTLE_CYCLES = 8;      // a byte yields at most three results
    localparam int DRAIN_LIMIT   = 20000;  // cycles allowed for the result queue to empty
    localparam int HDR_BYTES     = 34;     // file header plus info fields up to compression

    // Parse position of the local decoder model
    typedef enum logic [2:0] {
        ST_FILE_HDR, ST_INFO_HDR, ST_PALETTE, ST_PIXELS, ST_DONE
    } t_parse_state;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_decoded;

    // Directed byte with its result typed in: none, or one signature error
    typedef struct packed {
        logic [7:0] fb;
        logic       start;
        logic       sig_err;
    } t_byte_row;

    typedef struct packed {
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] info_len;
        logic [15:0] bitcount;
        logic [31:0] compression;
    } t_header;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic [7:0]           s_tdata     = 8'd0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tready    = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [TDATA_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    // Side band that travels with each request: use the typed result instead of the model
    bit                   row_typed   = 1'b0;
    bit                   row_sig_err = 1'b0;

    int                   send_idle_pct = 0;
    int                   stall_pct     = 0;
    bit                   hold_on       = 1'b0;
    event                 long_hold;

    t_decoded             expected_q[$];
    int                   n_fail  = 0;
    int                   n_bytes = 0;
    int                   kind_count[4] = '{0, 0, 0, 0};

    // Decoder model state
    t_parse_state         dec_state;
    logic [31:0]          hdr_count;
    logic [31:0]          info_len;
    logic [31:0]          img_w;
    logic [31:0]          img_h;
    logic [31:0]          bpp;
    logic [31:0]          field_sr;
    logic [31:0]          pal_count;
    logic [23:0]          quad;
    logic [31:0]          row_bytes;
    logic [31:0]          col;
    logic [31:0]          row_idx;

    bmp_palette_image_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_result make_result(input logic [1:0] kind, input logic [31:0] x,
                                            input logic [31:0] y, input logic [7:0] idx,
                                            input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [1:0] err);
        t_result res;
        res.kind        = kind;
        res.pos_x       = x[POS_W-1:0];
        res.pos_y       = y[POS_W-1:0];
        res.color_index = idx;
        res.red         = r;
        res.green       = g;
        res.blue        = b;
        res.error_code  = err;
        return res;
    endfunction

    function automatic string describe(input t_result r, input logic last);
        return $sformatf("kind %0d x %0d y %0d idx %0d rgb %h/%h/%h err %0d last %b",
                         r.kind, r.pos_x, r.pos_y, r.color_index, r.red, r.green, r.blue,
                         r.error_code, last);
    endfunction

    function automatic void clear_decoder();
        dec_state = ST_FILE_HDR;
        hdr_count = 0;
        info_len  = 0;
        img_w     = 0;
        img_h     = 0;
        bpp       = 0;
        field_sr  = 0;
        pal_count = 0;
        quad      = 0;
        row_bytes = 0;
        col       = 0;
        row_idx   = 0;
    endfunction

    // Advance the model by one file byte; queue its results unless the row is typed
    function automatic void decode_byte(input logic [7:0] fb, input logic start, input bit typed);
        t_result     found[$];
        t_decoded    item;
        logic [31:0] c;
        logic [31:0] flip_row;
        logic [31:0] stride;
        logic [1:0]  hdr_err;
        bit          bad;
        if (start)
            clear_decoder();
        case (dec_state)
            ST_FILE_HDR, ST_INFO_HDR: begin
                c         = hdr_count;
                field_sr  = {fb, field_sr[31:8]};
                hdr_count = c + 1;
                if (c == 1) begin
                    if ({field_sr[23:16], field_sr[31:24]} != BMP_SIG) begin
                        found.push_back(make_result(KIND_ERROR, 0, 0, 0, 0, 0, 0,
                                                    ERR_SIGNATURE));
                        dec_state = ST_DONE;
                    end
                end else if (c == 13) begin
                    dec_state = ST_INFO_HDR;
                end else if (c == 17) begin
                    info_len = field_sr;
                end else if (c == 21) begin
                    img_w = field_sr;
                end else if (c == 25) begin
                    img_h = field_sr;
                end else if (c == 29) begin
                    bpp = (field_sr[31:16] == 4 || field_sr[31:16] == 8) ? field_sr[31:16] : 0;
                end else if (c == 33) begin
                    // Compression wins over depth, depth over size
                    bad = 1'b1;
                    hdr_err = ERR_SIZE;
                    if (field_sr != 0)
                        hdr_err = ERR_COMPRESSED;
                    else if (bpp == 0)
                        hdr_err = ERR_DEPTH;
                    else if (info_len >= MIN_INFO_SIZE && info_len <= MAX_INFO_SIZE_DEF &&
                             img_w >= 1 && img_w <= MAX_DIM_DEF &&
                             img_h >= 1 && img_h <= MAX_DIM_DEF)
                        bad = 1'b0;
                    if (bad) begin
                        found.push_back(make_result(KIND_ERROR, 0, 0, 0, 0, 0, 0, hdr_err));
                        dec_state = ST_DONE;
                    end
                end else if (c > 33 && hdr_count == 14 + info_len) begin
                    dec_state = ST_PALETTE;
                    hdr_count = 0;
                    pal_count = 0;
                    quad      = 0;
                end
            end
            ST_PALETTE: begin
                // Quad order is blue, green, red, reserved; emit on the reserved byte
                c         = hdr_count & 3;
                hdr_count = (c + 1) & 3;
                if (c < 3) begin
                    quad = {quad[15:0], fb};
                end else begin
                    found.push_back(make_result(KIND_PALETTE, pal_count, 0, 0, quad[7:0],
                                                quad[15:8], quad[23:16], 0));
                    pal_count++;
                    quad = 0;
                    if (pal_count >= (32'd1 << bpp)) begin
                        dec_state = ST_PIXELS;
                        row_bytes = 0;
                        col       = 0;
                        row_idx   = 0;
                    end
                end
            end
            ST_PIXELS: begin
                flip_row = img_h - 1 - row_idx;
                if (bpp == 4) begin
                    if (col < img_w)
                        found.push_back(make_result(KIND_PIXEL, col, flip_row, {4'd0, fb[7:4]},
                                                    0, 0, 0, 0));
                    col++;
                    if (col < img_w)
                        found.push_back(make_result(KIND_PIXEL, col, flip_row, {4'd0, fb[3:0]},
                                                    0, 0, 0, 0));
                    col++;
                end else begin
                    if (col < img_w)
                        found.push_back(make_result(KIND_PIXEL, col, flip_row, fb, 0, 0, 0, 0));
                    col++;
                end
                row_bytes++;
                stride = ((img_w * bpp + 31) & 32'hFFFF_FFE0) >> 3;
                if (row_bytes >= stride) begin
                    row_bytes = 0;
                    col       = 0;
                    row_idx++;
                    if (row_idx >= img_h) begin
                        found.push_back(make_result(KIND_COMPLETE, 0, 0, 0, 0, 0, 0, 0));
                        dec_state = ST_DONE;
                    end
                end
            end
            default: ;
        endcase
        if (!typed) begin
            foreach (found[i]) begin
                item.res  = found[i];
                item.last = (i == found.size() - 1);
                expected_q.push_back(item);
            end
        end
    endfunction

    // Predict on every accepted request, then check every accepted result
    always @(posedge i_clk) begin : scoreboard
        t_decoded want;
        t_result  got;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                n_bytes++;
                decode_byte(s_tdata, s_tuser, row_typed);
                if (row_typed && row_sig_err) begin
                    want.res  = make_result(KIND_ERROR, 0, 0, 0, 0, 0, 0, ERR_SIGNATURE);
                    want.last = 1'b1;
                    expected_q.push_back(want);
                end
            end
            if (m_tvalid && m_tready) begin
                got.kind        = m_tuser;
                got.pos_x       = m_tdata[11:0];
                got.pos_y       = m_tdata[23:12];
                got.color_index = m_tdata[31:24];
                got.red         = m_tdata[39:32];
                got.green       = m_tdata[47:40];
                got.blue        = m_tdata[55:48];
                got.error_code  = m_tdata[57:56];
                if (expected_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result: %s", $time, describe(got, m_tlast));
                end else begin
                    want = expected_q.pop_front();
                    kind_count[want.res.kind]++;
                    if (got !== want.res || m_tdata[63:58] !== 6'd0 || m_tlast !== want.last) begin
                        n_fail++;
                        $display("%0t: mismatch, expected %s", $time, describe(want.res, want.last));
                        $display("%0t:           actual   %s (pad %h)", $time,
                                 describe(got, m_tlast), m_tdata[63:58]);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or a solid hold-off while long_hold runs
    always @(posedge i_clk) begin
        m_tready <= !hold_on && ($urandom_range(99) >= stall_pct);
    end

    initial forever begin
        @(long_hold);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Offer one byte after a random gap; return at the edge where the request is taken
    task automatic send_byte(input logic [7:0] fb, input logic start, input bit typed = 1'b0,
                             input bit sig_err = 1'b0);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= fb;
        s_tuser     <= start;
        row_typed   <= typed;
        row_sig_err <= sig_err;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
    endtask

    // Send a BMP file built from the given header; cut >= 0 truncates it there
    task automatic send_file(input t_header hd, input logic [15:0] sig = BMP_SIG,
                             input int cut = -1);
        logic [7:0]  head[HDR_BYTES];
        logic [7:0]  fill;
        logic [31:0] total;
        logic [31:0] stride;
        bit          ok;
        for (int i = 0; i < HDR_BYTES; i++)
            head[i] = 8'($urandom);
        head[0] = sig[15:8];
        head[1] = sig[7:0];
        {head[17], head[16], head[15], head[14]} = hd.info_len;
        {head[21], head[20], head[19], head[18]} = hd.width;
        {head[25], head[24], head[23], head[22]} = hd.height;
        {head[29], head[28]}                     = hd.bitcount;
        {head[33], head[32], head[31], head[30]} = hd.compression;
        ok = sig == BMP_SIG && hd.compression == 0 && (hd.bitcount == 4 || hd.bitcount == 8) &&
             hd.info_len >= MIN_INFO_SIZE && hd.info_len <= MAX_INFO_SIZE_DEF &&
             hd.width >= 1 && hd.width <= MAX_DIM_DEF &&
             hd.height >= 1 && hd.height <= MAX_DIM_DEF;
        if (ok) begin
            stride = ((hd.width * hd.bitcount + 31) / 32) * 4;
            total  = 14 + hd.info_len + (32'd4 << hd.bitcount) + stride * hd.height;
        end else begin
            // A rejected header leaves a few trailing bytes for the block to drop
            total = HDR_BYTES + $urandom_range(0, 3);
        end
        if (cut >= 0 && cut < total)
            total = cut;
        for (int unsigned i = 0; i < total; i++) begin
            fill = (i < HDR_BYTES) ? head[i] : 8'($urandom);
            send_byte(fill, i == 0);
        end
    endtask

    // Short traffic: broken headers, headers cut anywhere, and bursts of noise
    task automatic send_random_file();
        t_header     hd;
        logic [15:0] sig;
        int          pick;
        pick           = $urandom_range(99);
        sig            = BMP_SIG;
        hd.width       = $urandom_range(1, 12);
        hd.height      = $urandom_range(1, 3);
        hd.info_len    = ($urandom_range(3) == 0) ? $urandom_range(41, 56) : MIN_INFO_SIZE;
        hd.bitcount    = ($urandom_range(1) == 0) ? 16'd8 : 16'd4;
        hd.compression = 0;
        if (pick < 25) begin
            case ($urandom_range(5))
                0: sig = 16'($urandom);
                1: hd.compression = $urandom;
                2: hd.bitcount = 16'($urandom);
                3: hd.info_len = $urandom_range(1) ? $urandom_range(0, 39)
                                                   : $urandom_range(1025, 5000);
                4: hd.width = $urandom_range(1) ? 0 : $urandom_range(4097, 70000);
                default: hd.height = $urandom_range(1) ? 0 : $urandom;
            endcase
            send_file(hd, sig, HDR_BYTES + $urandom_range(0, 3));
        end else if (pick < 55) begin
            send_file(hd, sig, $urandom_range(1, HDR_BYTES));
        end else begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom), $urandom_range(3) == 0);
        end
    endtask

    // A small valid 4 bpp image; a width of 8 puts two pixels on the last byte of a row
    task automatic send_random_image();
        t_header hd;
        hd.width       = ($urandom_range(1) == 0) ? 32'd8 : 32'($urandom_range(1, 7));
        hd.height      = 32'($urandom_range(1, 2));
        hd.info_len    = 32'($urandom_range(40, 43));
        hd.bitcount    = 16'd4;
        hd.compression = 32'd0;
        send_file(hd);
    endtask

    // Drop valid, let every queued result arrive, then give the block a few more cycles
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        for (int k = 0; k < DRAIN_LIMIT && expected_q.size() != 0; k++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Signature handling, with each result typed in: none, or one signature error
    t_byte_row sig_rows[23] = '{
        '{8'h00, 1'b0, 1'b0},  // parse starts right after reset, no start flag needed
        '{8'hFF, 1'b0, 1'b1},
        '{8'h42, 1'b0, 1'b0},  // dropped after the error
        '{8'h4D, 1'b0, 1'b0},
        '{8'h4D, 1'b1, 1'b0},
        '{8'h42, 1'b0, 1'b1},  // swapped signature
        '{8'h42, 1'b1, 1'b0},
        '{8'h4D, 1'b0, 1'b0},  // good signature, header in progress
        '{8'h00, 1'b0, 1'b0},
        '{8'h42, 1'b1, 1'b0},  // restart in the middle of a header
        '{8'h4C, 1'b0, 1'b1},
        '{8'h42, 1'b1, 1'b0},
        '{8'hCD, 1'b0, 1'b1},
        '{8'hC2, 1'b1, 1'b0},
        '{8'h4D, 1'b0, 1'b1},
        '{8'hFF, 1'b1, 1'b0},
        '{8'hFF, 1'b0, 1'b1},
        '{8'h00, 1'b0, 1'b0},
        '{8'h00, 1'b1, 1'b0},
        '{8'h00, 1'b0, 1'b1},
        '{8'h42, 1'b1, 1'b0},
        '{8'h42, 1'b1, 1'b0},  // start again on what would be the second byte
        '{8'h4D, 1'b0, 1'b0}
    };

    // Headers failing validation, one per header error code; the first two test priority
    t_header bad_headers[3] = '{
        '{32'd5, 32'd2, 32'd40, 16'd24, 32'd1},        // compression beats depth
        '{32'd5, 32'd2, 32'd39, 16'h0108, 32'd0},      // depth beats info size
        '{32'd4097, 32'd2, 32'd40, 16'd4, 32'd0}       // width one past the limit
    };

    initial begin
        clear_decoder();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // No idling: signature rows, then header rejects under a long receiver hold-off
        foreach (sig_rows[i])
            send_byte(sig_rows[i].fb, sig_rows[i].start, 1'b1, sig_rows[i].sig_err);
        wait_idle();
        -> long_hold;
        foreach (bad_headers[i])
            send_file(bad_headers[i]);
        wait_idle();

        // Sender idle, receiver stalling, then both lightly with a full image
        for (int p = 0; p < 3; p++) begin
            send_idle_pct <= (p == 0) ? 80 : (p == 1) ? 0 : 15;
            stall_pct     <= (p == 0) ? 0 : (p == 1) ? 80 : 15;
            @(posedge i_clk);
            repeat (2) send_random_file();
            if (p == 2)
                send_random_image();
            wait_idle();
        end

        $display("Checked %0d file bytes: %0d palette entries, %0d pixels, %0d errors, %0d images",
                 n_bytes, kind_count[KIND_PALETTE], kind_count[KIND_PIXEL],
                 kind_count[KIND_ERROR], kind_count[KIND_COMPLETE]);
        $display("Covered signature and header rejects, restarts, a long output hold-off,");
        $display("a 4 bpp image with padding and four flow mixes");
        if (expected_q.size() != 0) begin
            n_fail++;
            $display("%0t: %0d results never arrived, first expected %s", $time,
                     expected_q.size(), describe(expected_q[0].res, expected_q[0].last));
        end
        if (n_fail == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bpid_pkg.sv
rtl/core/bmp_palette_image_decoder.sv
tb/sv/tb_bmp_palette_image_decoder.sv
